// ----- design/nklrd_pkg.sv -----
`timescale 1ns / 1ps

package nklrd_pkg;

  localparam int CORES_DEF      = 4;
  localparam int SEQ_BITS_DEF   = 32;
  localparam int DEPTH_BITS_DEF = 8;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [3:0] {
    OP_ENTER         = 4'd0,
    OP_LEAVE         = 4'd1,
    OP_DETACH        = 4'd2,
    OP_ATTACH        = 4'd3,
    OP_DROP          = 4'd4,
    OP_SWITCH_UNLOCK = 4'd5,
    OP_ASK           = 4'd6,
    OP_SELF          = 4'd7,
    OP_OWE           = 4'd8,
    OP_OWED          = 4'd9,
    OP_TAKE          = 4'd10,
    OP_HELD          = 4'd11
  } op_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load_req;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

endpackage

// ----- design/nklrd_ctrl.sv -----
`timescale 1ns / 1ps

module nklrd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  nklrd_pkg::dp_stat_t   stat,
  output nklrd_pkg::ctrl_cmd_t  cmd
);

  nklrd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nklrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nklrd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = nklrd_pkg::ST_EXEC;
      end
      nklrd_pkg::ST_EXEC: begin
        if (!stat.out_blocked) state_nxt = nklrd_pkg::ST_IDLE;
      end
      default: state_nxt = nklrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_req = 1'b0;
    cmd.exec     = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      nklrd_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      nklrd_pkg::ST_EXEC: begin
        // wait here while the previous result is still unclaimed
        cmd.exec = !stat.out_blocked;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/nklrd_dp.sv -----
`timescale 1ns / 1ps

module nklrd_dp #(
  parameter int CORES      = nklrd_pkg::CORES_DEF,
  parameter int SEQ_BITS   = nklrd_pkg::SEQ_BITS_DEF,
  parameter int DEPTH_BITS = nklrd_pkg::DEPTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nklrd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [nklrd_pkg::IN_USER_W-1:0]     in_tuser,
  input  nklrd_pkg::ctrl_cmd_t                cmd,
  output nklrd_pkg::dp_stat_t                 stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nklrd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;

  // request latch
  logic [1:0] req_core_r;
  logic [3:0] req_mask_r;
  logic [7:0] req_dval_r;
  logic [3:0] req_op_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_core_r <= in_tdata[1:0];
      req_mask_r <= in_tdata[5:2];
      req_dval_r <= in_tdata[13:6];
      req_op_r   <= in_tuser[3:0];
    end
  end

  // per-core state; the reschedule matrix keeps asked minus taken per pair,
  // which is all that the pending test depends on
  logic [DEPTH_BITS-1:0] depth_r [CORES];
  logic                  owed_r  [CORES];
  logic [SEQ_BITS-1:0]   diff_r  [CORES][CORES];

  logic                  in_range;
  logic [CIDX_W-1:0]     me;
  logic [CORES-1:0]      pend;
  logic [CORES-1:0]      own_vec;
  logic [CORES-1:0]      mask_vec;
  logic [7:0]            mask8;
  logic [3:0]            lim4;
  logic [3:0]            own4;
  logic [DEPTH_BITS-1:0] cur_depth;
  logic                  cur_owed;
  logic                  pend_me;

  assign in_range  = int'(req_core_r) < CORES;
  assign me        = CIDX_W'(req_core_r);
  assign mask8     = 8'(req_mask_r);
  assign own4      = 4'(1) << req_core_r;
  assign cur_depth = depth_r[me];
  assign cur_owed  = owed_r[me];
  assign pend_me   = pend[me];

  always_comb begin
    for (int t = 0; t < CORES; t++) begin
      pend[t] = 1'b0;
      for (int f = 0; f < CORES; f++) begin
        pend[t] = pend[t] | (diff_r[f][t] != '0);
      end
      own_vec[t]  = (CIDX_W'(t) == me);
      mask_vec[t] = mask8[t];
    end
    for (int i = 0; i < 4; i++) begin
      lim4[i] = (i < CORES);
    end
  end

  // operation decode
  logic [DEPTH_BITS-1:0] nd;
  logic                  no;
  logic                  wr_st;
  logic                  acq, rel, flg, err, use_cur;
  logic [3:0]            ipi;
  logic [CORES-1:0]      owe_vec;
  logic                  take;
  logic                  op_ok;

  always_comb begin
    nd      = cur_depth;
    no      = cur_owed;
    wr_st   = 1'b0;
    acq     = 1'b0;
    rel     = 1'b0;
    flg     = 1'b0;
    err     = 1'b0;
    use_cur = 1'b0;
    ipi     = '0;
    owe_vec = '0;
    take    = 1'b0;
    op_ok   = 1'b1;
    unique case (nklrd_pkg::op_t'(req_op_r))
      nklrd_pkg::OP_ENTER: begin
        if (cur_depth == '1) begin
          err = 1'b1;
        end else begin
          acq   = (cur_depth == '0) && !cur_owed;
          nd    = cur_depth + 1'b1;
          wr_st = 1'b1;
        end
      end
      nklrd_pkg::OP_LEAVE: begin
        if (cur_depth == '0) begin
          err = 1'b1;
        end else begin
          nd    = cur_depth - 1'b1;
          wr_st = 1'b1;
          if (nd == '0 && !cur_owed) begin
            rel = 1'b1;
            if (pend_me) ipi = own4;
          end
        end
      end
      nklrd_pkg::OP_DETACH: begin
        use_cur = 1'b1;
        nd      = '0;
        no      = 1'b1;
        wr_st   = 1'b1;
      end
      nklrd_pkg::OP_ATTACH: begin
        acq   = !cur_owed;
        nd    = DEPTH_BITS'(req_dval_r);
        wr_st = 1'b1;
      end
      nklrd_pkg::OP_DROP, nklrd_pkg::OP_SWITCH_UNLOCK: begin
        nd    = '0;
        no    = 1'b0;
        wr_st = 1'b1;
        rel   = 1'b1;
        if (nklrd_pkg::op_t'(req_op_r) == nklrd_pkg::OP_SWITCH_UNLOCK && pend_me) ipi = own4;
      end
      nklrd_pkg::OP_ASK: begin
        owe_vec = mask_vec & ~own_vec;
        ipi     = req_mask_r & lim4 & ~own4;
      end
      nklrd_pkg::OP_SELF: owe_vec = own_vec;
      nklrd_pkg::OP_OWE:  owe_vec = mask_vec;
      nklrd_pkg::OP_OWED: flg = pend_me;
      nklrd_pkg::OP_TAKE: begin
        take = 1'b1;
        flg  = pend_me;
      end
      nklrd_pkg::OP_HELD: flg = (cur_depth != '0) || cur_owed;
      // spare opcodes: no state change, all-zero result
      default: op_ok = 1'b0;
    endcase
  end

  logic upd;
  assign upd = cmd.exec && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORES; i++) begin
        depth_r[i] <= '0;
        owed_r[i]  <= 1'b0;
        for (int j = 0; j < CORES; j++) begin
          diff_r[i][j] <= '0;
        end
      end
    end else if (upd) begin
      if (wr_st) begin
        depth_r[me] <= nd;
        owed_r[me]  <= no;
      end
      for (int f = 0; f < CORES; f++) begin
        for (int t = 0; t < CORES; t++) begin
          if (take && own_vec[t]) begin
            diff_r[f][t] <= '0;
          end else if (own_vec[f] && owe_vec[t]) begin
            diff_r[f][t] <= diff_r[f][t] + 1'b1;
          end
        end
      end
    end
  end

  // output register
  logic                                 out_valid_r;
  logic [nklrd_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic [7:0]                           dout;

  assign dout = use_cur ? 8'(cur_depth) : 8'(nd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (in_range && op_ok) begin
        out_data_r <= {err, flg, dout, ipi, rel, acq};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;
  assign stat.out_blocked = out_valid_r && !out_tready;

endmodule

// ----- design/nested_kernel_lock_resched_doorbell_core.sv -----
`timescale 1ns / 1ps

// Per-core kernel lock bookkeeping with reschedule doorbells. Each request
// (core, operation, target mask, attach depth) yields one result carrying the
// acquire/release command for the external ticket lock, an IPI raise mask,
// a depth and status/error bits. Each request is first latched from the
// transfer; then the controller has the datapath evaluate it against
// the per-core depth/owed registers and the reschedule counter matrix, commit
// the update and load the output register. The input side is ready again as
// soon as the result is loaded; if the output register is still held by the
// sink, evaluation of the next request waits until it drains. Enter at the
// maximum depth or leave at zero depth reports error and leaves state as is.
module nested_kernel_lock_resched_doorbell_core #(
  parameter int CORES      = nklrd_pkg::CORES_DEF,
  parameter int SEQ_BITS   = nklrd_pkg::SEQ_BITS_DEF,
  parameter int DEPTH_BITS = nklrd_pkg::DEPTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // core[1:0], core_mask[5:2], depth_value[13:6], zero[15:14]
  input  logic [nklrd_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[3:0]
  input  logic [nklrd_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // acquire_lock[0], release_lock[1], ipi_mask[5:2], depth_out[13:6],
  // flag[14], error[15]
  output logic [nklrd_pkg::OUT_DATA_W-1:0]  out_tdata
);

  nklrd_pkg::ctrl_cmd_t cmd;
  nklrd_pkg::dp_stat_t  stat;

  nklrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nklrd_dp #(
    .CORES      (CORES),
    .SEQ_BITS   (SEQ_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // one request in flight: after a transfer the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is being evaluated");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15]) |-> (out_tdata[5:0] == 6'd0 && !out_tdata[14]))
    else $error("error result carries lock, ipi or flag bits");

  a_acq_rel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("acquire and release in one result");

endmodule

// ----- sim/nested_kernel_lock_resched_doorbell_core_tb.sv -----
`timescale 1ns / 1ps

module nested_kernel_lock_resched_doorbell_core_tb;

  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [7:0] DEPTH_TOP   = {nklrd_pkg::DEPTH_BITS_DEF{1'b1}};
  localparam int         RAND_ITEMS  = 2000;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] core;
    logic [3:0] mask;
    logic [7:0] dval;
    logic       wait_idle;
  } lock_req_t;

  // same bit order as out_tdata, acquire in bit 0
  typedef struct packed {
    logic       error;
    logic       flag;
    logic [7:0] depth;
    logic [3:0] ipi;
    logic       rel;
    logic       acq;
  } lock_res_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [nklrd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [nklrd_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [nklrd_pkg::OUT_DATA_W-1:0] out_tdata;

  lock_req_t req_q[$];
  lock_res_t result_q[$];

  logic [7:0]  depth_m [4];
  logic        owed_m [4];
  logic [31:0] asked_m [4][4];  // [from][to]
  logic [31:0] taken_m [4][4];  // [me][from]

  logic in_taken = 1'b0;
  int   src_gap = 0;
  int   snk_gap = 0;
  int   mismatches = 0;

  nested_kernel_lock_resched_doorbell_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic resched_pending(logic [1:0] me);
    for (int f = 0; f < 4; f++) begin
      if (asked_m[f][me] != taken_m[me][f]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow state and returns the result it yields.
  function automatic lock_res_t lock_result(lock_req_t r);
    lock_res_t  res;
    logic [1:0] me;
    logic [3:0] m;
    res = '0;
    me = r.core;
    m = r.mask;
    if (r.op > nklrd_pkg::OP_HELD) return res;
    case (r.op)
      nklrd_pkg::OP_ENTER: begin
        if (depth_m[me] == DEPTH_TOP) begin
          res.error = 1'b1;
        end else begin
          res.acq = (depth_m[me] == 0) && !owed_m[me];
          depth_m[me] = depth_m[me] + 1'b1;
        end
      end
      nklrd_pkg::OP_LEAVE: begin
        if (depth_m[me] == 0) begin
          res.error = 1'b1;
        end else begin
          depth_m[me] = depth_m[me] - 1'b1;
          if (depth_m[me] == 0 && !owed_m[me]) begin
            res.rel = 1'b1;
            if (resched_pending(me)) res.ipi = 4'b1 << me;
          end
        end
      end
      nklrd_pkg::OP_DETACH: begin
        res.depth = depth_m[me];
        depth_m[me] = '0;
        owed_m[me] = 1'b1;
      end
      nklrd_pkg::OP_ATTACH: begin
        res.acq = !owed_m[me];
        depth_m[me] = r.dval;
      end
      nklrd_pkg::OP_DROP, nklrd_pkg::OP_SWITCH_UNLOCK: begin
        depth_m[me] = '0;
        owed_m[me] = 1'b0;
        res.rel = 1'b1;
        if (r.op == nklrd_pkg::OP_SWITCH_UNLOCK && resched_pending(me))
          res.ipi = 4'b1 << me;
      end
      nklrd_pkg::OP_ASK, nklrd_pkg::OP_SELF, nklrd_pkg::OP_OWE: begin
        if (r.op == nklrd_pkg::OP_ASK) m = m & ~(4'b1 << me);
        if (r.op == nklrd_pkg::OP_SELF) m = 4'b1 << me;
        for (int t = 0; t < 4; t++) begin
          if (m[t]) asked_m[me][t] = asked_m[me][t] + 1;
        end
        if (r.op == nklrd_pkg::OP_ASK) res.ipi = m;
      end
      nklrd_pkg::OP_OWED: res.flag = resched_pending(me);
      nklrd_pkg::OP_TAKE: begin
        for (int f = 0; f < 4; f++) begin
          if (asked_m[f][me] != taken_m[me][f]) begin
            taken_m[me][f] = asked_m[f][me];
            res.flag = 1'b1;
          end
        end
      end
      default: res.flag = (depth_m[me] != 0) || owed_m[me];
    endcase
    if (r.op != nklrd_pkg::OP_DETACH) res.depth = depth_m[me];
    return res;
  endfunction

  // idling stays off near the end and in every third stretch of 200 items
  function automatic logic idle_on();
    return req_q.size() > 300 && ((req_q.size() / 200) % 3 != 0);
  endfunction

  task automatic add(logic [3:0] op, int core, int mask, int dval);
    lock_req_t r;
    r.op = op;
    r.core = core[1:0];
    r.mask = mask[3:0];
    r.dval = dval[7:0];
    r.wait_idle = 1'b0;
    req_q.push_back(r);
  endtask

  task automatic add_rand(logic [3:0] op, int core);
    add(op, core, $urandom_range(0, 15), $urandom_range(0, 255));
  endtask

  // source side
  always @(negedge clk) begin
    lock_req_t nxt;
    logic      drive;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      drive = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
      end else if (req_q.size() != 0 && !(req_q[0].wait_idle && result_q.size() != 0)) begin
        nxt = req_q.pop_front();
        in_tuser <= nxt.op;
        in_tdata <= {2'b00, nxt.dval, nxt.mask, nxt.core};
        drive = 1'b1;
        if (idle_on() && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 12);
      end
      in_tvalid <= drive;
    end
  end

  // sink side
  always @(negedge clk) begin
    if (rst_n) begin
      if (snk_gap != 0) begin
        snk_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on() && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 12);
      end
    end
  end

  // monitor: check result transfers, then predict for the request transfer
  always @(posedge clk) begin
    lock_res_t got;
    lock_res_t want;
    lock_req_t r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: unexpected result %h", got);
        end else begin
          want = result_q.pop_front();
          if (got.acq !== want.acq || got.rel !== want.rel || got.ipi !== want.ipi ||
              got.depth !== want.depth || got.flag !== want.flag ||
              got.error !== want.error) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tb: mismatch exp acq=%0d rel=%0d ipi=%h depth=%0d flag=%0d ",
                        "err=%0d, got acq=%0d rel=%0d ipi=%h depth=%0d flag=%0d err=%0d"},
                       want.acq, want.rel, want.ipi, want.depth, want.flag, want.error,
                       got.acq, got.rel, got.ipi, got.depth, got.flag, got.error);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        r = {in_tuser, in_tdata[1:0], in_tdata[5:2], in_tdata[13:6], 1'b0};
        result_q.push_back(lock_result(r));
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    int c;
    int k;
    for (int i = 0; i < 4; i++) begin
      depth_m[i] = '0;
      owed_m[i] = 1'b0;
      for (int j = 0; j < 4; j++) begin
        asked_m[i][j] = '0;
        taken_m[i][j] = '0;
      end
    end

    // directed: idle queries, nesting, depth limits, detach/attach, doorbells
    add(nklrd_pkg::OP_HELD, 0, 0, 0);
    add(nklrd_pkg::OP_OWED, 0, 15, 255);
    add(nklrd_pkg::OP_ENTER, 0, 0, 0);
    add(nklrd_pkg::OP_ENTER, 0, 15, 255);
    add(nklrd_pkg::OP_LEAVE, 0, 0, 0);
    add(nklrd_pkg::OP_LEAVE, 0, 0, 0);
    add(nklrd_pkg::OP_LEAVE, 0, 0, 0);         // underflow
    add(nklrd_pkg::OP_ATTACH, 1, 0, 255);
    add(nklrd_pkg::OP_ENTER, 1, 0, 0);         // overflow
    add(nklrd_pkg::OP_DETACH, 1, 0, 0);
    add(nklrd_pkg::OP_ENTER, 1, 0, 0);         // owed, no acquire
    add(nklrd_pkg::OP_HELD, 1, 0, 0);
    add(nklrd_pkg::OP_ATTACH, 1, 15, 0);
    add(nklrd_pkg::OP_SWITCH_UNLOCK, 1, 0, 0);
    add(nklrd_pkg::OP_ASK, 2, 15, 0);
    add(nklrd_pkg::OP_SELF, 3, 0, 0);
    add(nklrd_pkg::OP_OWE, 0, 15, 170);
    add(nklrd_pkg::OP_OWED, 3, 0, 0);
    add(nklrd_pkg::OP_ENTER, 3, 0, 0);
    add(nklrd_pkg::OP_LEAVE, 3, 0, 0);         // release with own doorbell
    add(nklrd_pkg::OP_TAKE, 3, 0, 0);
    add(nklrd_pkg::OP_TAKE, 3, 0, 0);
    add(nklrd_pkg::OP_DROP, 2, 5, 85);
    add(OP_SPARE_LO, 1, 10, 85);
    add(OP_SPARE_HI, 2, 5, 170);

    while (req_q.size() < RAND_ITEMS + 25) begin
      c = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          k = $urandom_range(1, 3);
          repeat (k) add_rand(nklrd_pkg::OP_ENTER, c);
          if ($urandom_range(0, 1)) add_rand(nklrd_pkg::OP_ASK, c);
          if ($urandom_range(0, 3) == 0) add_rand(nklrd_pkg::OP_HELD, c);
          repeat (k) add_rand(nklrd_pkg::OP_LEAVE, c);
        end
        3: begin
          add_rand(nklrd_pkg::OP_DETACH, c);
          if ($urandom_range(0, 1)) add_rand(4'($urandom_range(0, 11)), c);
          if ($urandom_range(0, 3) == 0)
            add(nklrd_pkg::OP_ATTACH, c, $urandom_range(0, 15), 255 - $urandom_range(0, 1));
          else
            add_rand(nklrd_pkg::OP_ATTACH, c);
          add_rand(nklrd_pkg::OP_ENTER, c);
        end
        4: begin
          add_rand($urandom_range(0, 1) ? nklrd_pkg::OP_OWE : nklrd_pkg::OP_SELF, c);
          k = $urandom_range(0, 3);
          add_rand(nklrd_pkg::OP_OWED, k);
          add_rand(nklrd_pkg::OP_TAKE, k);
        end
        5: add_rand($urandom_range(0, 1) ? nklrd_pkg::OP_DROP : nklrd_pkg::OP_SWITCH_UNLOCK, c);
        6: add_rand(nklrd_pkg::OP_LEAVE, c);
        default: add_rand(4'($urandom_range(0, 15)), c);
      endcase
    end
    req_q[1000].wait_idle = 1'b1;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
design/nklrd_pkg.sv
design/nklrd_ctrl.sv
design/nklrd_dp.sv
design/nested_kernel_lock_resched_doorbell_core.sv
sim/nested_kernel_lock_resched_doorbell_core_tb.sv
